[sv/lfrc_pkg.sv]
// ----------------------------------------------------------------------------
// lfrc_pkg
// Shared types, constants and helpers for the LIN frame receive checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrc_pkg;

  localparam int SLOTS_DEF    = 4;
  localparam int MAX_DATA_DEF = 8;

  localparam logic [7:0] LIN_SYNC_PATTERN = 8'h55;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ENHANCED   = 2'd0;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd1;
  localparam logic [1:0] REG_SLOT_IDS   = 2'd2;
  localparam logic [1:0] REG_SLOT_SIZES = 2'd3;

  localparam logic [2:0]  SLOT_COUNT_RST = 3'd1;
  localparam logic [15:0] SLOT_SIZES_RST = 16'h8888;

  localparam logic KIND_HEADER   = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_PID   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } lfrc_phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } lfrc_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] slot;
    logic       sync_ok;
    logic       pid_ok;
    logic       checksum_ok;
    logic [7:0] received_value;
    logic [7:0] expected_value;
  } lfrc_out_t;

  typedef struct packed {
    logic        enhanced_checksum;
    logic [2:0]  slot_count;
    logic [23:0] slot_ids;
    logic [15:0] slot_sizes;
  } lfrc_cfg_t;

  // queued check request: ref_val holds the raw frame ID (header) or the
  // running sum (response)
  typedef struct packed {
    logic       kind;
    logic [1:0] slot;
    logic       sync_good;
    logic [7:0] rx_byte;
    logic [7:0] ref_val;
  } lfrc_req_t;

  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

`default_nettype wire

[sv/lin_frame_receive_checker.sv]
// Flow: a request that yields a result is queued at its input edge, then moves
// into the output register and shows on out_valid once the result stage is free.
// Throughput: one input request per cycle; the parser never waits on the result
// stage unless the two-entry queue between them is full.
// Reset: rst_n clears the parser to idle (waiting for a break), slot 0, and
// the registers to classic checksum, one slot, IDs 0 and sizes 0x8888.
// ----------------------------------------------------------------------------
// lin_frame_receive_checker
// LIN header and checksum checker: parser, request queue, result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_frame_receive_checker
  import lfrc_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lfrc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lfrc_out_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lfrc_cfg_t cfg;
  logic      q_full, q_push, q_pop, q_not_empty;
  lfrc_req_t q_req, q_head;

  lfrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfrc_front #(
    .SLOTS    (SLOTS),
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (q_req)
  );

  lfrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (q_req),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lfrc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

[sv/lfrc_regs.sv]
// ----------------------------------------------------------------------------
// lfrc_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrc_regs
  import lfrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output lfrc_cfg_t        cfg
);

  lfrc_cfg_t cfg_r, cfg_nxt;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_ENHANCED:   cfg_nxt.enhanced_checksum = pwdata[0];
        REG_SLOT_COUNT: cfg_nxt.slot_count        = pwdata[2:0];
        REG_SLOT_IDS:   cfg_nxt.slot_ids          = pwdata[23:0];
        REG_SLOT_SIZES: cfg_nxt.slot_sizes        = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENHANCED:   prdata = {31'd0, cfg_r.enhanced_checksum};
      REG_SLOT_COUNT: prdata = {29'd0, cfg_r.slot_count};
      REG_SLOT_IDS:   prdata = {8'd0, cfg_r.slot_ids};
      REG_SLOT_SIZES: prdata = {16'd0, cfg_r.slot_sizes};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enhanced_checksum <= 1'b0;
      cfg_r.slot_count        <= SLOT_COUNT_RST;
      cfg_r.slot_ids          <= 24'd0;
      cfg_r.slot_sizes        <= SLOT_SIZES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/lfrc_front.sv]
// ----------------------------------------------------------------------------
// lfrc_front
// Byte parser: tracks the frame phase, accumulates the checksum and queues
// one check request at the PID byte and at the checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrc_front
  import lfrc_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire lfrc_in_t  in_data,
  output logic           in_ready,
  input  wire lfrc_cfg_t cfg,
  input  wire logic      q_full,
  output logic           q_push,
  output lfrc_req_t      q_req
);

  localparam logic [2:0] ACT_CAP = 3'((SLOTS < 4) ? SLOTS : 4);
  localparam logic [3:0] LEN_CAP = 4'((MAX_DATA < 8) ? MAX_DATA : 8);

  lfrc_phase_t phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic        sync_good_r, sync_good_nxt;

  logic       acc;
  logic [3:0] count_inc;
  logic [3:0] raw_len, slot_len;
  logic [2:0] active;
  logic [2:0] slot_inc;
  logic [8:0] sum_wide;
  logic [7:0] sum_add;
  logic [4:0] id_base;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  assign count_inc = count_r + 4'd1;
  assign raw_len   = cfg.slot_sizes[{slot_r, 2'b00} +: 4];
  assign slot_len  = (raw_len == 4'd0) ? 4'd1 : ((raw_len > LEN_CAP) ? LEN_CAP : raw_len);
  assign active    = (cfg.slot_count == 3'd0) ? 3'd1 :
                     ((cfg.slot_count > ACT_CAP) ? ACT_CAP : cfg.slot_count);
  assign slot_inc  = {1'b0, slot_r} + 3'd1;
  // end-around carry sum
  assign sum_wide  = {1'b0, sum_r} + {1'b0, in_data.rx_byte};
  assign sum_add   = sum_wide[7:0] + {7'd0, sum_wide[8]};
  assign id_base   = 5'(slot_r) * 5'd6;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_data.mode) begin
        phase_nxt = PH_SYNC;
      end else begin
        case (phase_r)
          PH_SYNC:  phase_nxt = PH_PID;
          PH_PID:   phase_nxt = PH_DATA;
          PH_DATA:  phase_nxt = (count_inc >= slot_len) ? PH_CHECK : PH_DATA;
          PH_CHECK: phase_nxt = PH_IDLE;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // datapath and queue requests
  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    sync_good_nxt = sync_good_r;
    q_push        = 1'b0;
    q_req.kind      = KIND_HEADER;
    q_req.slot      = slot_r;
    q_req.sync_good = sync_good_r;
    q_req.rx_byte   = in_data.rx_byte;
    q_req.ref_val   = {2'b00, cfg.slot_ids[id_base +: 6]};
    if (acc) begin
      if (in_data.mode) begin
        count_nxt     = 4'd0;
        sum_nxt       = 8'd0;
        sync_good_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_SYNC: begin
            sync_good_nxt = (in_data.rx_byte == LIN_SYNC_PATTERN);
          end
          PH_PID: begin
            q_push    = 1'b1;
            count_nxt = 4'd0;
            sum_nxt   = cfg.enhanced_checksum ? in_data.rx_byte : 8'd0;
          end
          PH_DATA: begin
            sum_nxt   = sum_add;
            count_nxt = count_inc;
          end
          PH_CHECK: begin
            q_push        = 1'b1;
            q_req.kind    = KIND_RESPONSE;
            q_req.ref_val = sum_r;
            slot_nxt      = (slot_inc >= active) ? 2'd0 : slot_inc[1:0];
            count_nxt     = 4'd0;
            sum_nxt       = 8'd0;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= 4'd0;
      sum_r       <= 8'd0;
      slot_r      <= 2'd0;
      sync_good_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      sync_good_r <= sync_good_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/lfrc_queue.sv]
// ----------------------------------------------------------------------------
// lfrc_queue
// Two-entry request queue between parser and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrc_queue
  import lfrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire lfrc_req_t push_req,
  input  wire logic      pop,
  output logic           full,
  output logic           not_empty,
  output lfrc_req_t      head
);

  lfrc_req_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/lfrc_back.sv]
// ----------------------------------------------------------------------------
// lfrc_back
// Result stage: computes protected ID or inverted checksum, compares and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrc_back
  import lfrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_not_empty,
  input  wire lfrc_req_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lfrc_out_t      out_data
);

  logic      out_valid_r, out_valid_nxt;
  lfrc_out_t out_data_r, res;
  logic [7:0] exp_val;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    exp_val = (q_head.kind == KIND_HEADER) ? protect_id(q_head.ref_val[5:0])
                                           : ~q_head.ref_val;
    res.result_kind    = q_head.kind;
    res.slot           = q_head.slot;
    res.received_value = q_head.rx_byte;
    res.expected_value = exp_val;
    if (q_head.kind == KIND_HEADER) begin
      res.sync_ok     = q_head.sync_good;
      res.pid_ok      = (q_head.rx_byte == exp_val);
      res.checksum_ok = 1'b0;
    end else begin
      res.sync_ok     = 1'b0;
      res.pid_ok      = 1'b0;
      res.checksum_ok = (q_head.rx_byte == exp_val);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/lfrc_checker.sv]
// ----------------------------------------------------------------------------
// lfrc_checker
// Port-level assertions for the LIN frame receive checker.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrc_checker
  import lfrc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire lfrc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_HEADER |->
      !out_data.checksum_ok &&
      out_data.pid_ok == (out_data.received_value == out_data.expected_value))
    else $error("header result fields inconsistent");

  a_response_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_RESPONSE |->
      !out_data.sync_ok && !out_data.pid_ok &&
      out_data.checksum_ok == (out_data.received_value == out_data.expected_value))
    else $error("response result fields inconsistent");

  a_header_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_HEADER |->
      out_data.expected_value == protect_id(out_data.expected_value[5:0]))
    else $error("expected PID parity wrong");

endmodule

bind lin_frame_receive_checker lfrc_checker u_lfrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
